/* rtl/gwm_pkg.sv */
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants for the glob wildcard matcher: register map, field
// widths and the two wildcard byte codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_LEN_W  = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD3  = 3'd4;

  // Pattern bytes packed per configuration word
  localparam int BYTES_PER_WORD = 8;

  // Wildcard codes
  localparam logic [7:0] CH_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CH_ANY_RUN = 8'h2A;  // '*'

endpackage : gwm_pkg

`default_nettype wire

/* rtl/glob_wildcard_matcher.sv */
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Whole-string glob matcher over a byte stream.
// ----------------------------------------------------------------------------
// Takes one text byte per request and one request per cycle unless stalled. A
// request is captured in an input register; once it moves on from there, the live
// position set (one flag per pattern position) is updated for that byte in a
// single pass, and for a request that ends the string the verdict is loaded
// into the result register in the same step, so a result is valid once its
// request leaves the input register. The input side stalls only while a final
// request waits for the result register to be emptied. In the pattern '?'
// matches any one byte and '*' any run of bytes, the empty run too. Program
// the pattern while no request is in flight; the set kept mid-string is read
// under the current pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input requests
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_text_byte,
  input  wire logic                           in_no_byte,
  input  wire logic                           in_last_byte,
  // results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_matched
);
  import gwm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int P     = MAX_PATTERN_BYTES + 1;

  logic [MAX_PATTERN_BYTES-1:0][7:0] pat_bytes;
  logic [LEN_W-1:0]                  pat_len;

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_no_byte_r;
  logic         s1_last_r;
  logic [P-1:0] live_r;
  logic [P-1:0] live_upd;
  logic         step_matched;
  logic         out_valid_r;
  logic         out_matched_r;

  logic in_take;
  logic out_free;
  logic s1_go;

  gwm_cfg_regs #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .LEN_W             (LEN_W)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pat_bytes (pat_bytes),
    .pat_len   (pat_len)
  );

  gwm_step #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .LEN_W             (LEN_W)
  ) u_step (
    .live      (live_r),
    .text_byte (s1_byte_r),
    .no_byte   (s1_no_byte_r),
    .pat_bytes (pat_bytes),
    .pat_len   (pat_len),
    .live_nxt  (live_upd),
    .matched   (step_matched)
  );

  // Handshake: a final request needs room in the result register
  assign out_free     = !out_valid_r || !out_stall;
  assign s1_go        = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall     = s1_valid_r && !s1_go;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r    <= in_text_byte;
      s1_no_byte_r <= in_no_byte;
      s1_last_r    <= in_last_byte;
    end
  end

  // Live position set; back to the start state after each string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= P'(1);
    end else if (s1_go) begin
      live_r <= s1_last_r ? P'(1) : live_upd;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_matched_r <= step_matched;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule : glob_wildcard_matcher

`default_nettype wire

/* rtl/gwm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// gwm_cfg_regs
// Pattern register file: holds the pattern bytes and the pattern length,
// and presents the length clamped to the pattern storage size.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cfg_regs #(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [gwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gwm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic      [MAX_PATTERN_BYTES-1:0][7:0] pat_bytes,
  output logic      [LEN_W-1:0]                 pat_len
);
  import gwm_pkg::*;

  logic [CFG_LEN_W-1:0]               len_r;
  logic [MAX_PATTERN_BYTES-1:0][7:0]  pat_r;

  // Length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we && cfg_index == REG_LENGTH) begin
      len_r <= cfg_wdata[CFG_LEN_W-1:0];
    end
  end

  // Pattern bytes, one register per stored byte
  for (genvar b = 0; b < MAX_PATTERN_BYTES; b++) begin : g_byte
    localparam logic [CFG_IDX_W-1:0] WordIdx =
      CFG_IDX_W'(REG_WORD0 + b / BYTES_PER_WORD);
    localparam int Lsb = 8 * (b % BYTES_PER_WORD);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pat_r[b] <= '0;
      end else if (cfg_we && cfg_index == WordIdx) begin
        pat_r[b] <= cfg_wdata[Lsb +: 8];
      end
    end
  end

  // Lengths beyond the storage size count as the full storage size
  always_comb begin
    if (len_r > CFG_LEN_W'(MAX_PATTERN_BYTES)) begin
      pat_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      pat_len = len_r[LEN_W-1:0];
    end
  end

  assign pat_bytes = pat_r;

endmodule : gwm_cfg_regs

`default_nettype wire

/* rtl/gwm_step.sv */
// ----------------------------------------------------------------------------
// gwm_step
// Bit-parallel update of the live position set for one text byte (none for
// a byte-less request) and the whole-string verdict for the resulting set.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_step #(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  wire logic [MAX_PATTERN_BYTES:0]        live,
  input  wire logic [7:0]                        text_byte,
  input  wire logic                              no_byte,
  input  wire logic [MAX_PATTERN_BYTES-1:0][7:0] pat_bytes,
  input  wire logic [LEN_W-1:0]                  pat_len,
  output logic      [MAX_PATTERN_BYTES:0]        live_nxt,
  output logic                                   matched
);
  import gwm_pkg::*;

  localparam int N = MAX_PATTERN_BYTES;
  localparam int P = MAX_PATTERN_BYTES + 1;

  logic [N-1:0] star;     // position is an in-use '*'
  logic [N-1:0] single;   // position consumes this byte
  logic [P-1:0] star_p;
  logic [P-1:0] closed;
  logic [P-1:0] adv;
  logic [P-1:0] final_set;

  // Star closure as a carry chain: a live star starts a carry that runs
  // through the following stars and lands on the first non-star position.
  function automatic logic [P-1:0] close_stars(input logic [P-1:0] s,
                                               input logic [P-1:0] t);
    logic [P-1:0] sum;
    sum = t + (s & t);
    return s | (sum ^ t);
  endfunction

  // Per-position pattern decode
  always_comb begin
    for (int i = 0; i < N; i++) begin
      star[i]   = (LEN_W'(i) < pat_len) && (pat_bytes[i] == CH_ANY_RUN);
      single[i] = (LEN_W'(i) < pat_len) && (pat_bytes[i] != CH_ANY_RUN) &&
                  ((pat_bytes[i] == CH_ANY_ONE) || (pat_bytes[i] == text_byte));
    end
  end

  assign star_p = {1'b0, star};
  assign closed = close_stars(live, star_p);

  // Stars stay put, other positions step forward on a match
  assign adv = {1'b0, closed[N-1:0] & star} | {closed[N-1:0] & single, 1'b0};

  assign live_nxt  = no_byte ? live : adv;
  assign final_set = close_stars(live_nxt, star_p);
  assign matched   = final_set[pat_len];

endmodule : gwm_step

`default_nettype wire

/* rtl/gwm_checker.sv */
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks for the glob wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_last_byte,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_matched
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A held result keeps its verdict
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched))
    else $error("stalled result changed");

  // With the result register empty the input never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // A final request taken with the result register empty passes through the input
  // register into the result register when the result side does not hold it back
  a_last_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte && !out_valid) ##1 !out_stall
      |=> out_valid)
    else $error("final request produced no result");

endmodule : gwm_checker

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_last_byte (in_last_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_matched  (out_matched)
);

`default_nettype wire

/* test/glob_wildcard_matcher_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_test
// Self-checking bench for the streamed glob matcher. A directed table covers
// the empty pattern, wildcards, byte extremes, an oversized length, an
// ignored register index and a pattern swap mid-string; random phases follow,
// each with a fresh pattern and mostly pattern-shaped strings. Verdicts come
// from the table or a model of the live position set and are checked in order.
// ----------------------------------------------------------------------------

module glob_wildcard_matcher_test;

  import gwm_pkg::*;

  localparam int MAX_BYTES     = 32;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_WORD3 + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;
  localparam logic [7:0]           LETTER_A        = "a";

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {VERDICT_PREDICT, VERDICT_MATCH, VERDICT_NO_MATCH} verdict_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic [7:0]             text;
    logic                   nob;
    logic                   last;
    verdict_t               verdict;
  } row_t;

  typedef logic [7:0] text_t [$];

  // Directed table: register writes and requests in order
  localparam int DIRECTED_ROWS = 36;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty pattern after reset: only the empty string matches
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'h00, 1'b1, 1'b1, VERDICT_MATCH},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b1, VERDICT_NO_MATCH},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'h55, 1'b1, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'hAA, 1'b1, 1'b1, VERDICT_MATCH},
    // pattern a?c*
    '{ROW_REG,  REG_WORD0,  64'h0000_0000_2A63_3F61, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_LENGTH, 64'd4, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "a",   1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "c",   1'b0, 1'b0, VERDICT_PREDICT},
    // string ended by a byte-less request, star takes the empty run
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'h00, 1'b1, 1'b1, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "a",   1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "c",   1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'h2A, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b1, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "a",   1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "x",   1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "d",   1'b0, 1'b1, VERDICT_PREDICT},
    // 31 stars then z; length field all ones clamps to the full pattern
    '{ROW_REG,  REG_WORD0,  64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_WORD1,  64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_WORD2,  64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_WORD3,  64'h7A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "z",   1'b0, 1'b1, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "q",   1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "y",   1'b0, 1'b1, VERDICT_PREDICT},
    // write to an unmapped index changes nothing
    '{ROW_REG,  REG_SPARE_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "z",   1'b0, 1'b1, VERDICT_PREDICT},
    // zero byte in the pattern is a plain literal
    '{ROW_REG,  REG_WORD0,  64'd0, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_LENGTH, 64'd1, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, 8'h00, 1'b0, 1'b1, VERDICT_PREDICT},
    // pattern swapped from ab to ac while a string is open
    '{ROW_REG,  REG_WORD0,  64'h6261, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "a",   1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_REG,  REG_WORD0,  64'h6361, 8'h00, 1'b0, 1'b0, VERDICT_PREDICT},
    '{ROW_ITEM, REG_LENGTH, 64'd0, "c",   1'b0, 1'b1, VERDICT_PREDICT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_text_byte = '0;
  logic                  in_no_byte = 1'b0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_matched;

  glob_wildcard_matcher u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_no_byte   (in_no_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_matched  (out_matched)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Matcher model: pattern registers and live position set
  logic [5:0]  pat_len_q;
  logic [63:0] pat_words [4];
  logic [32:0] live_set;

  logic        pending_verdicts [$];
  int          error_count;
  int          requests_done;
  int          random_start;
  int          quiet_cycles;
  int          stall_left;
  bit          idle_on;
  logic        verdict_seen;

  function automatic int used_len();
    return (pat_len_q > MAX_BYTES) ? MAX_BYTES : int'(pat_len_q);
  endfunction

  function automatic logic [7:0] pat_char(int i);
    return pat_words[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * 8 +: 8];
  endfunction

  // Let every live star also stand for the empty run
  function automatic logic [32:0] close_runs(logic [32:0] set);
    int n;
    int i;
    n = used_len();
    for (i = 0; i < n; i++)
      if (set[i] && pat_char(i) == CH_ANY_RUN) set[i + 1] = 1'b1;
    return set;
  endfunction

  function automatic logic [32:0] advance_set(logic [32:0] set, logic [7:0] c);
    logic [32:0] nxt;
    logic [7:0]  p;
    int          n;
    int          i;
    n   = used_len();
    nxt = '0;
    set = close_runs(set);
    for (i = 0; i < n; i++) begin
      if (set[i]) begin
        p = pat_char(i);
        if (p == CH_ANY_RUN) nxt[i] = 1'b1;
        else if (p == CH_ANY_ONE || p == c) nxt[i + 1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  // Apply one accepted request; returns the verdict for a final request
  function automatic logic match_request(logic [7:0] c, logic nob, logic last);
    logic [32:0] set;
    set = live_set;
    if (!nob) set = advance_set(set, c);
    if (!last) begin
      live_set = set;
      return 1'b0;
    end
    set      = close_runs(set);
    live_set = 33'd1;
    return set[used_len()];
  endfunction

  function automatic void note_reg_write(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    if (idx == REG_LENGTH) pat_len_q = data[5:0];
    else if (idx <= REG_WORD3) pat_words[2'(idx - REG_WORD0)] = data;
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return CH_ANY_RUN;
    if (r == 1) return CH_ANY_ONE;
    return LETTER_A + 8'($urandom_range(0, 2));
  endfunction

  // Drop valid, wait out pending verdicts and in-flight bytes
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    note_reg_write(idx, data);
  endtask

  task automatic send_request(input logic [7:0] c, input logic nob, input logic last,
                              input verdict_t verdict);
    int   gap;
    logic predicted;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= c;
    in_no_byte   <= nob;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    predicted = match_request(c, nob, last);
    if (last) begin
      case (verdict)
        VERDICT_MATCH:    pending_verdicts.push_back(1'b1);
        VERDICT_NO_MATCH: pending_verdicts.push_back(1'b0);
        default:          pending_verdicts.push_back(predicted);
      endcase
    end
    if (!nob || last) requests_done++;
  endtask

  // Text shaped by the current pattern, sometimes damaged, else free-form
  task automatic make_text(output text_t txt);
    int         n;
    int         k;
    int         r;
    int         pos;
    logic [7:0] p;
    txt = {};
    r   = $urandom_range(0, 9);
    if (r < 7) begin
      n = used_len();
      for (k = 0; k < n; k++) begin
        p = pat_char(k);
        if (p == CH_ANY_RUN) repeat ($urandom_range(0, 3)) txt.push_back(random_letter());
        else if (p == CH_ANY_ONE) txt.push_back(8'($urandom));
        else txt.push_back(p);
      end
      if (r >= 4) begin
        if (txt.size() == 0) txt.push_back(random_letter());
        else begin
          pos = $urandom_range(0, txt.size() - 1);
          case ($urandom_range(0, 2))
            0:       txt[pos] = random_letter();
            1:       txt.delete(pos);
            default: txt.insert(pos, random_letter());
          endcase
        end
      end
    end else begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
      repeat (n) txt.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : random_letter());
    end
  endtask

  // One string; an open string is left without its final request
  task automatic send_string(input bit closed);
    text_t txt;
    bit    empty_end;
    int    k;
    make_text(txt);
    empty_end = (txt.size() == 0) || ($urandom_range(0, 7) == 0);
    for (k = 0; k < txt.size(); k++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(8'($urandom), 1'b1, 1'b0, VERDICT_PREDICT);
      send_request(txt[k], 1'b0, closed && !empty_end && k == txt.size() - 1,
                   VERDICT_PREDICT);
    end
    if (closed && empty_end) send_request(8'($urandom), 1'b1, 1'b1, VERDICT_PREDICT);
  endtask

  task automatic program_random_pattern();
    logic [CFG_DATA_W-1:0] word;
    logic [5:0]            len;
    int                    w;
    int                    j;
    int                    r;
    for (w = 0; w < 4; w++) begin
      word = {$urandom, $urandom};
      for (j = 0; j < BYTES_PER_WORD; j++) begin
        r = $urandom_range(0, 9);
        if (r < 5) word[j * 8 +: 8] = LETTER_A + 8'($urandom_range(0, 2));
        else if (r < 7) word[j * 8 +: 8] = CH_ANY_ONE;
        else if (r < 9) word[j * 8 +: 8] = CH_ANY_RUN;
      end
      write_reg(REG_WORD0 + CFG_IDX_W'(w), word);
    end
    r = $urandom_range(0, 9);
    if (r == 0) len = '0;
    else if (r == 1) len = 6'(MAX_BYTES);
    else if (r == 2) len = 6'($urandom_range(MAX_BYTES + 1, 63));
    else len = 6'($urandom_range(1, 8));
    word      = {$urandom, $urandom};
    word[5:0] = len;
    write_reg(REG_LENGTH, word);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                {$urandom, $urandom});
  endtask

  // Result side: check in order, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("matched: no result expected, got %0b", out_matched);
        error_count++;
      end else begin
        verdict_seen = pending_verdicts.pop_front();
        if (out_matched !== verdict_seen) begin
          $error("matched: expected %0b, got %0b", verdict_seen, out_matched);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = idle_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog on cycles with no request, result or register write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence
  initial begin
    pat_len_q = '0;
    for (int w = 0; w < 4; w++) pat_words[w] = '0;
    live_set      = 33'd1;
    error_count   = 0;
    requests_done = 0;
    quiet_cycles  = 0;
    stall_left    = 0;
    idle_on       = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_REG)
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
      else
        send_request(DIRECTED[r].text, DIRECTED[r].nob, DIRECTED[r].last,
                     DIRECTED[r].verdict);
    end

    // Random phases, each under a fresh pattern; stop once the budget is spent
    random_start = requests_done;
    while (requests_done - random_start < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      program_random_pattern();
      for (int s = $urandom_range(5, 20);
           s > 0 && requests_done - random_start < RANDOM_ITEMS; s--)
        send_string(1'b1);
      if ($urandom_range(0, 3) == 0 && requests_done - random_start < RANDOM_ITEMS)
        send_string(1'b0);
    end

    settle();
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule : glob_wildcard_matcher_test

/* sim.f */
rtl/gwm_pkg.sv
rtl/gwm_cfg_regs.sv
rtl/gwm_step.sv
rtl/glob_wildcard_matcher.sv
rtl/gwm_checker.sv
test/glob_wildcard_matcher_test.sv
